// File: rtl/oqr_pkg.sv
`timescale 1ns / 1ps

package oqr_pkg;

   localparam int ID_W = 31;

   typedef enum logic [1:0] {
      OP_APPEND = 2'd0,
      OP_REMOVE = 2'd1,
      OP_LIST   = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STAT_OK        = 2'd0,
      STAT_FULL      = 2'd1,
      STAT_NOT_FOUND = 2'd2,
      STAT_EMPTY     = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_APPEND,
      CELL_REMOVE,
      CELL_ROTATE
   } cell_cmd_type;

   typedef enum logic {
      FSM_IDLE,
      FSM_LIST
   } fsm_type;

   typedef struct packed {
      cell_cmd_type    cmd;
      logic [ID_W-1:0] id;
   } cell_ctrl_type;

endpackage

// File: rtl/oqr_cell.sv
`timescale 1ns / 1ps

module oqr_cell
   import oqr_pkg::*;
#(
   parameter int INDEX   = 0,
   parameter int COUNT_W = 5
) (
   input  logic                clock,
   input  cell_ctrl_type       ctrl,
   input  logic [COUNT_W-1:0]  count,
   input  logic                hit_in,
   input  logic [ID_W-1:0]     next_id,
   input  logic [ID_W-1:0]     head_id,
   output logic [ID_W-1:0]     id_out,
   output logic                hit_out
);

   logic [ID_W-1:0] id_ff;
   logic [ID_W-1:0] id_in;
   logic            occupied;
   logic            is_tail;
   logic            is_last_occ;

   assign occupied    = COUNT_W'(INDEX) < count;
   assign is_tail     = COUNT_W'(INDEX) == count;
   assign is_last_occ = COUNT_W'(INDEX + 1) == count;
   assign hit_out     = hit_in | (occupied && (id_ff == ctrl.id));
   assign id_out      = id_ff;

   always_comb begin
      id_in = id_ff;
      case (ctrl.cmd)
         CELL_APPEND: begin
            if (is_tail) begin
               id_in = ctrl.id;
            end
         end
         CELL_REMOVE: begin
            if (hit_out) begin
               id_in = next_id;
            end
         end
         CELL_ROTATE: begin
            if (is_last_occ) begin
               id_in = head_id;
            end else begin
               id_in = next_id;
            end
         end
         default: begin
            id_in = id_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      id_ff <= id_in;
   end

endmodule

// File: rtl/ordered_queue_with_remove_by_id.sv
// Ordered queue of ids, oldest first, held in a row of cells. A transaction is taken when start
// is high and busy is low. Append, remove and any other code give one result in the next cycle
// and leave busy low, so one such transaction can be taken in every cycle. Remove compares every
// cell against the request id in the same cycle and closes the gap by shifting the cells above
// the first match toward the head; append fills the tail cell. A list of n stored ids holds busy
// high and gives n results back to back, the first registered after the list state is entered
// and the last, marked by rsp_is_last, as busy falls; the ids come out of the head cell as the
// chain rotates by one cell per cycle, which leaves the order unchanged when it ends. A list of
// an empty queue gives a single result with the empty status. Results are shown for one cycle on
// rsp_valid and cannot be held off, so the receiver must take each one as it appears.
`timescale 1ns / 1ps

module ordered_queue_with_remove_by_id
   import oqr_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [1:0]                        req_op,
   input  logic [ID_W-1:0]                   req_item_id,
   output logic                              rsp_valid,
   output logic [1:0]                        rsp_status,
   output logic [ID_W-1:0]                   rsp_out_id,
   output logic [$clog2(QUEUE_DEPTH+1)-1:0]  rsp_fill_count,
   output logic                              rsp_is_last
);

   localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);

   fsm_type             state_ff, state_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic [COUNT_W-1:0]  remain_ff, remain_in;
   logic                rsp_valid_ff, rsp_valid_in;
   status_type          rsp_status_ff, rsp_status_in;
   logic [ID_W-1:0]     rsp_id_ff, rsp_id_in;
   logic [COUNT_W-1:0]  rsp_count_ff;
   logic                rsp_last_ff, rsp_last_in;
   cell_ctrl_type       cell_ctrl;
   logic [ID_W-1:0]     cell_id [QUEUE_DEPTH];
   logic [QUEUE_DEPTH:0] hit;
   logic                full;

   assign hit[0] = 1'b0;
   assign full   = count_ff == COUNT_W'(QUEUE_DEPTH);

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      logic [ID_W-1:0] next_id;
      if (i == QUEUE_DEPTH - 1) begin : g_end
         assign next_id = cell_id[i];
      end else begin : g_mid
         assign next_id = cell_id[i+1];
      end
      oqr_cell #(
         .INDEX   (i),
         .COUNT_W (COUNT_W)
      ) u_cell (
         .clock   (clock),
         .ctrl    (cell_ctrl),
         .count   (count_ff),
         .hit_in  (hit[i]),
         .next_id (next_id),
         .head_id (cell_id[0]),
         .id_out  (cell_id[i]),
         .hit_out (hit[i+1])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_IDLE;
         count_ff     <= '0;
         remain_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         remain_ff    <= remain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_count_ff  <= count_in;
      rsp_last_ff   <= rsp_last_in;
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      remain_in     = remain_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = STAT_OK;
      rsp_id_in     = req_item_id;
      rsp_last_in   = 1'b1;
      cell_ctrl.cmd = CELL_HOLD;
      cell_ctrl.id  = req_item_id;
      case (state_ff)
         FSM_IDLE: begin
            if (start) begin
               case (op_type'(req_op))
                  OP_APPEND: begin
                     rsp_valid_in = 1'b1;
                     if (full) begin
                        rsp_status_in = STAT_FULL;
                     end else begin
                        cell_ctrl.cmd = CELL_APPEND;
                        count_in      = count_ff + 1'b1;
                     end
                  end
                  OP_REMOVE: begin
                     rsp_valid_in = 1'b1;
                     if (count_ff == '0) begin
                        rsp_status_in = STAT_EMPTY;
                     end else if (!hit[QUEUE_DEPTH]) begin
                        rsp_status_in = STAT_NOT_FOUND;
                     end else begin
                        cell_ctrl.cmd = CELL_REMOVE;
                        count_in      = count_ff - 1'b1;
                     end
                  end
                  OP_LIST: begin
                     if (count_ff == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STAT_EMPTY;
                        rsp_id_in     = '0;
                     end else begin
                        state_in  = FSM_LIST;
                        remain_in = count_ff;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         FSM_LIST: begin
            rsp_valid_in  = 1'b1;
            rsp_id_in     = cell_id[0];
            rsp_last_in   = remain_ff == COUNT_W'(1);
            cell_ctrl.cmd = CELL_ROTATE;
            remain_in     = remain_ff - 1'b1;
            if (remain_ff == COUNT_W'(1)) begin
               state_in = FSM_IDLE;
            end
         end
         default: begin
            state_in = FSM_IDLE;
         end
      endcase
   end

   assign busy           = state_ff == FSM_LIST;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_out_id     = rsp_id_ff;
   assign rsp_fill_count = rsp_count_ff;
   assign rsp_is_last    = rsp_last_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(QUEUE_DEPTH))
      else $error("Fill count exceeds the queue depth.");

   a_list_remain: assert property (@(posedge clock) disable iff (reset)
      state_ff == FSM_LIST |-> (remain_ff != '0) && (remain_ff <= count_ff))
      else $error("List walk counter out of range.");

   a_list_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == FSM_LIST) && (remain_ff == COUNT_W'(1))
      |=> (state_ff == FSM_IDLE) && rsp_valid_ff && rsp_last_ff)
      else $error("List walk did not end with a final result.");

   a_append_grow: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_op == OP_APPEND) && !full
      |=> count_ff == $past(count_ff) + 1'b1)
      else $error("Append did not grow the queue.");

   a_list_count_stable: assert property (@(posedge clock) disable iff (reset)
      (state_ff == FSM_LIST) |=> $stable(count_ff))
      else $error("Fill count changed during a list walk.");

endmodule
